// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/cds_pkg.sv =====
package cds_pkg;

   localparam int STEP_WIDTH      = 24;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_STEP_RATIO  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FRAME_COUNT = 1'd1;

   // most results one input beat may cause
   localparam logic [1:0] RUN_LIMIT = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_GATHER,
      ST_MUL,
      ST_ACC,
      ST_ADVANCE,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/cubic_downsampler.sv =====
// an input beat holds the block until its n results (n = 0..3) are issued, longer
//   while the result register is stalled, and new input beats stall meanwhile; one
//   shared multiplier runs the three horner passes of each result, each pass a
//   multiply step then an accumulate step
// reset: synchronous, clears control, step ratio to 1.0, frame count to 1,
//   sample history, input index and output position to zero
module cubic_downsampler import cds_pkg::*; #(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int FRACTION_BITS = 16,
   parameter int COUNT_WIDTH   = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_in_sample,
   input  logic                           req_clip_start,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_sample,
   output logic                           rsp_run_last,
   output logic                           rsp_clip_last,
   input  logic                           csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [((COUNT_WIDTH > STEP_WIDTH) ? COUNT_WIDTH : STEP_WIDTH)-1:0] csr_data
);

   localparam int PW    = COUNT_WIDTH + FRACTION_BITS;
   localparam int EFF_W = (FRACTION_BITS >= STEP_WIDTH) ? FRACTION_BITS + 1 : STEP_WIDTH;
   localparam int SUMW  = ((PW > EFF_W) ? PW : EFF_W) + 1;
   localparam int IW    = COUNT_WIDTH + 2;
   localparam int HW    = SAMPLE_WIDTH + 6;
   localparam int PRW   = HW + FRACTION_BITS + 1;

   localparam logic [EFF_W-1:0]      ONE_STEP   = EFF_W'(64'd1 << FRACTION_BITS);
   localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(64'd1 << FRACTION_BITS);
   localparam logic signed [PRW-1:0] RND_HALF   = PRW'(64'd1 << (FRACTION_BITS - 1));
   localparam logic signed [HW-1:0]  SAT_MAX    = HW'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
   localparam logic signed [HW-1:0]  SAT_MIN    = ~SAT_MAX;

   localparam logic [1:0] TAP_CUR   = 2'd0;
   localparam logic [1:0] TAP_PREV1 = 2'd1;
   localparam logic [1:0] TAP_PREV2 = 2'd2;
   localparam logic [1:0] TAP_OLD   = 2'd3;

   localparam logic [1:0] PASS_B = 2'd0;
   localparam logic [1:0] PASS_C = 2'd1;
   localparam logic [1:0] PASS_D = 2'd2;

   function automatic logic [1:0] tap_code(input logic [2:0] back);
      tap_code = (back >= 3'(TAP_OLD)) ? TAP_OLD : back[1:0];
   endfunction

   function automatic logic signed [HW-1:0] tap_pick(
      input logic [1:0]                     code,
      input logic signed [SAMPLE_WIDTH-1:0] cur,
      input logic signed [SAMPLE_WIDTH-1:0] prev1,
      input logic signed [SAMPLE_WIDTH-1:0] prev2,
      input logic signed [SAMPLE_WIDTH-1:0] old
   );
      logic signed [SAMPLE_WIDTH-1:0] v;
      case (code)
         TAP_CUR:   v = cur;
         TAP_PREV1: v = prev1;
         TAP_PREV2: v = prev2;
         default:   v = old;
      endcase
      tap_pick = {{(HW - SAMPLE_WIDTH){v[SAMPLE_WIDTH-1]}}, v};
   endfunction

   state_type                      state_ff, state_in;
   logic [STEP_WIDTH-1:0]          step_ratio_ff, step_ratio_in;
   logic [COUNT_WIDTH-1:0]         frame_count_ff, frame_count_in;
   logic signed [SAMPLE_WIDTH-1:0] hist0_ff, hist0_in;
   logic signed [SAMPLE_WIDTH-1:0] hist1_ff, hist1_in;
   logic signed [SAMPLE_WIDTH-1:0] hist2_ff, hist2_in;
   logic [COUNT_WIDTH-1:0]         index_ff, index_in;
   logic [PW-1:0]                  pos_ff, pos_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic signed [SAMPLE_WIDTH-1:0] cur_ff, cur_in;
   logic [1:0]                     count_ff, count_in;
   logic [1:0]                     pass_ff, pass_in;
   logic signed [HW-1:0]           h_ff, h_in;
   logic signed [HW-1:0]           coef_b_ff, coef_b_in;
   logic signed [HW-1:0]           coef_c_ff, coef_c_in;
   logic signed [HW-1:0]           coef_d_ff, coef_d_in;
   logic signed [PRW-1:0]          prod_ff, prod_in;
   logic signed [SAMPLE_WIDTH-1:0] res_ff, res_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic                           rsp_run_last_ff, rsp_run_last_in;
   logic                           rsp_clip_last_ff, rsp_clip_last_in;

   logic                    req_accept;
   logic [EFF_W-1:0]        step_eff;
   logic [SUMW-1:0]         pos_sum;
   logic [SUMW-1:0]         limit_val;
   logic                    fits;
   logic [COUNT_WIDTH-1:0]  p_idx;
   logic                    ahead_ok;
   logic                    is_last;
   logic                    in_range;
   logic                    more;
   logic [COUNT_WIDTH-1:0]  lag;
   logic [2:0]              dsat;
   logic                    j2_inside;
   logic                    j3_inside;
   logic [1:0]              code0, code1, code2, code3;
   logic signed [HW-1:0]    y0, y1, y2, y3;
   logic signed [HW-1:0]    coef_a;
   logic signed [FRACTION_BITS:0] t_s;
   logic signed [PRW-1:0]   rsum;
   logic signed [PRW-1:0]   rsh;
   logic signed [HW-1:0]    coef_sel;
   logic signed [HW-1:0]    h_inc;
   logic signed [HW-1:0]    h_half;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);

   // position bookkeeping
   assign step_eff  = (EFF_W'(step_ratio_ff) < ONE_STEP) ? ONE_STEP : EFF_W'(step_ratio_ff);
   assign pos_sum   = SUMW'(pos_ff) + SUMW'(step_eff);
   assign limit_val = SUMW'({frame_count_ff, {FRACTION_BITS{1'b0}}});
   assign fits      = (pos_sum <= limit_val);
   assign p_idx     = pos_ff[PW-1:FRACTION_BITS];
   assign ahead_ok  = (IW'(p_idx) + IW'(2)) <= IW'(index_ff);
   assign is_last   = (IW'(index_ff) + IW'(1)) == IW'(frame_count_ff);
   assign in_range  = (index_ff < frame_count_ff);
   assign more      = (count_ff != RUN_LIMIT) && fits && (is_last || ahead_ok);

   // neighbour taps by distance back from the current sample, clamped at clip edges
   assign lag       = index_ff - p_idx;
   assign dsat      = (lag > COUNT_WIDTH'(5)) ? 3'd5 : lag[2:0];
   assign j2_inside = (IW'(p_idx) + IW'(1)) < IW'(frame_count_ff);
   assign j3_inside = (IW'(p_idx) + IW'(2)) < IW'(frame_count_ff);
   assign code1     = tap_code(dsat);
   assign code0     = (p_idx == '0) ? code1 : tap_code(dsat + 3'd1);
   assign code2     = (!j2_inside || dsat == 3'd0) ? TAP_CUR : tap_code(dsat - 3'd1);
   assign code3     = (!j3_inside || dsat <= 3'd1) ? TAP_CUR : tap_code(dsat - 3'd2);
   assign y0        = tap_pick(code0, cur_ff, hist2_ff, hist1_ff, hist0_ff);
   assign y1        = tap_pick(code1, cur_ff, hist2_ff, hist1_ff, hist0_ff);
   assign y2        = tap_pick(code2, cur_ff, hist2_ff, hist1_ff, hist0_ff);
   assign y3        = tap_pick(code3, cur_ff, hist2_ff, hist1_ff, hist0_ff);
   assign coef_a    = -y0 + (y1 <<< 1) + y1 - ((y2 <<< 1) + y2) + y3;

   // shared multiply and rounding
   assign t_s   = $signed({1'b0, pos_ff[FRACTION_BITS-1:0]});
   assign rsum  = prod_ff + RND_HALF;
   assign rsh   = rsum >>> FRACTION_BITS;

   always_comb begin
      case (pass_ff)
         PASS_B:  coef_sel = coef_b_ff;
         PASS_C:  coef_sel = coef_c_ff;
         default: coef_sel = coef_d_ff;
      endcase
   end

   assign h_inc  = h_ff + $signed(HW'(1));
   assign h_half = h_inc >>> 1;

   always_comb begin
      state_in         = state_ff;
      step_ratio_in    = step_ratio_ff;
      frame_count_in   = frame_count_ff;
      hist0_in         = hist0_ff;
      hist1_in         = hist1_ff;
      hist2_in         = hist2_ff;
      index_in         = index_ff;
      pos_in           = pos_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      cur_in           = cur_ff;
      count_in         = count_ff;
      pass_in          = pass_ff;
      h_in             = h_ff;
      coef_b_in        = coef_b_ff;
      coef_c_in        = coef_c_ff;
      coef_d_in        = coef_d_ff;
      prod_in          = prod_ff;
      res_in           = res_ff;
      rsp_sample_in    = rsp_sample_ff;
      rsp_run_last_in  = rsp_run_last_ff;
      rsp_clip_last_in = rsp_clip_last_ff;

      if (csr_write) begin
         case (csr_index)
            REG_STEP_RATIO:  step_ratio_in  = csr_data[STEP_WIDTH-1:0];
            REG_FRAME_COUNT: frame_count_in = csr_data[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cur_in   = req_in_sample;
               count_in = '0;
               if (req_clip_start) begin
                  hist0_in = '0;
                  hist1_in = '0;
                  hist2_in = '0;
                  index_in = '0;
                  pos_in   = '0;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!in_range) begin
               state_in = ST_IDLE;
            end else if (more) begin
               state_in = ST_GATHER;
            end else begin
               hist0_in = hist1_ff;
               hist1_in = hist2_ff;
               hist2_in = cur_ff;
               index_in = index_ff + COUNT_WIDTH'(1);
               state_in = ST_IDLE;
            end
         end
         ST_GATHER: begin
            h_in      = coef_a;
            coef_b_in = (y0 <<< 1) - ((y1 <<< 2) + y1) + (y2 <<< 2) - y3;
            coef_c_in = y2 - y0;
            coef_d_in = y1 <<< 1;
            pass_in   = PASS_B;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = h_ff * t_s;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            h_in = $signed(rsh[HW-1:0]) + coef_sel;
            if (pass_ff == PASS_D) begin
               state_in = ST_ADVANCE;
            end else begin
               pass_in  = pass_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_ADVANCE: begin
            if (h_half > SAT_MAX) begin
               res_in = SAT_MAX[SAMPLE_WIDTH-1:0];
            end else if (h_half < SAT_MIN) begin
               res_in = SAT_MIN[SAMPLE_WIDTH-1:0];
            end else begin
               res_in = h_half[SAMPLE_WIDTH-1:0];
            end
            pos_in   = pos_sum[PW-1:0];
            count_in = count_ff + 2'd1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_sample_in    = res_ff;
               rsp_run_last_in  = !more;
               rsp_clip_last_in = !fits;
               if (more) begin
                  state_in = ST_GATHER;
               end else begin
                  hist0_in = hist1_ff;
                  hist1_in = hist2_ff;
                  hist2_in = cur_ff;
                  index_in = index_ff + COUNT_WIDTH'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ratio_ff  <= STEP_RESET;
         frame_count_ff <= COUNT_WIDTH'(1);
         hist0_ff       <= '0;
         hist1_ff       <= '0;
         hist2_ff       <= '0;
         index_ff       <= '0;
         pos_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ratio_ff  <= step_ratio_in;
         frame_count_ff <= frame_count_in;
         hist0_ff       <= hist0_in;
         hist1_ff       <= hist1_in;
         hist2_ff       <= hist2_in;
         index_ff       <= index_in;
         pos_ff         <= pos_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff           <= cur_in;
      count_ff         <= count_in;
      pass_ff          <= pass_in;
      h_ff             <= h_in;
      coef_b_ff        <= coef_b_in;
      coef_c_ff        <= coef_c_in;
      coef_d_ff        <= coef_d_in;
      prod_ff          <= prod_in;
      res_ff           <= res_in;
      rsp_sample_ff    <= rsp_sample_in;
      rsp_run_last_ff  <= rsp_run_last_in;
      rsp_clip_last_ff <= rsp_clip_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_sample_ff;
   assign rsp_run_last   = rsp_run_last_ff;
   assign rsp_clip_last  = rsp_clip_last_ff;

endmodule

// ===== rtl/cds_checker.sv =====
`include "assert_macros.svh"

module cds_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_out_sample,
   input logic                           rsp_run_last,
   input logic                           rsp_clip_last
);

   // a stalled result beat stays put
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_sample) && $stable(rsp_run_last) && $stable(rsp_clip_last))

   // one input beat at a time
   `ASSERT_NEXT(a_req_busy, clock, reset, req_valid && !req_stall, req_stall)

   // the end of the clip also ends the run of its input beat
   `ASSERT_NOW(a_clip_ends_run, clock, reset, rsp_valid && rsp_clip_last, rsp_run_last)

   // reset leaves the block idle with no result pending
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule

bind cubic_downsampler cds_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_cds_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_sample(rsp_out_sample),
   .rsp_run_last  (rsp_run_last),
   .rsp_clip_last (rsp_clip_last)
);
